// ===== rtl/core/icv_pkg.sv =====
package icv_pkg;

    // File size bound and table size bound
    localparam logic [32:0] MAX_FILE_BYTES = 33'd536870912;
    localparam logic [8:0]  MAX_ENTRIES    = 9'd256;

    // Widths of the stream counters
    localparam int POS_W = 30;
    localparam int OFS_W = 33;

    // Format selector codes
    localparam logic FMT_ICO  = 1'b0;
    localparam logic FMT_ICNS = 1'b1;

    // ICO header and entry constants
    localparam logic [15:0] ICO_TYPE_ICON  = 16'd1;
    localparam logic [15:0] ICO_PLANES     = 16'd1;
    localparam logic [15:0] ICO_BPP        = 16'd32;
    localparam logic [32:0] ICO_DIR_BASE   = 33'd6;

    // ICNS constants
    localparam logic [31:0] ICNS_MAGIC     = 32'h69636e73;
    localparam logic [31:0] ICNS_MIN_CHUNK = 32'd9;
    localparam logic [POS_W-1:0] ICNS_MIN_LEN = 30'd17;
    localparam logic [OFS_W-1:0] ICNS_HDR_LEN = 33'd8;

    // Verdict handed from the parser to the output stage
    typedef struct packed {
        logic       ok;
        logic [8:0] count;
    } verdict_t;

endpackage

// ===== rtl/core/icv_parser.sv =====
module icv_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clear,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic              format_sel,
    output icv_pkg::verdict_t verdict
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_TABLE,
        PH_BODY,
        PH_CHUNKHDR
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic [icv_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [31:0]                shift_reg, shift_next;
    logic [8:0]                 total_reg, total_next;
    logic [8:0]                 index_reg, index_next;
    logic [icv_pkg::OFS_W-1:0]  offset_reg, offset_next;
    logic [31:0]                declared_reg, declared_next;
    logic [icv_pkg::OFS_W-1:0]  boundary_reg, boundary_next;
    logic [8:0]                 tally_reg, tally_next;
    logic                       failed_reg, failed_next;

    logic [31:0]                shift_ico;
    logic [31:0]                shift_icns;
    logic [15:0]                half;
    logic [3:0]                 rel;
    logic [icv_pkg::OFS_W-1:0]  pos_wide;
    logic [icv_pkg::OFS_W-1:0]  len_wide;
    logic [1:0]                 magic_sel;
    logic [7:0]                 magic_byte;

    assign shift_ico  = {data_byte, shift_reg[31:8]};
    assign shift_icns = {shift_reg[23:0], data_byte};
    assign half       = shift_ico[31:16];
    assign rel        = pos_reg[3:0] - 4'd6;
    assign pos_wide   = {{(icv_pkg::OFS_W-icv_pkg::POS_W){1'b0}}, pos_reg};
    assign magic_sel  = pos_reg[1:0];
    assign magic_byte = icv_pkg::ICNS_MAGIC[8*(3-magic_sel) +: 8];

    // Per-byte parse step, written in the order the checks apply
    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        shift_next    = shift_reg;
        total_next    = total_reg;
        index_next    = index_reg;
        offset_next   = offset_reg;
        declared_next = declared_reg;
        boundary_next = boundary_reg;
        tally_next    = tally_reg;
        failed_next   = failed_reg;

        if (pos_wide >= icv_pkg::MAX_FILE_BYTES) begin
            failed_next = 1'b1;
        end else begin
            pos_next = pos_reg + 1'b1;
            if (!failed_reg) begin
                if (format_sel == icv_pkg::FMT_ICNS) begin
                    shift_next = shift_icns;
                    if (phase_reg == PH_HEADER) begin
                        if (pos_reg < 30'd4 && data_byte != magic_byte) begin
                            failed_next = 1'b1;
                        end
                        if (pos_reg == 30'd7) begin
                            declared_next = shift_icns;
                            boundary_next = icv_pkg::ICNS_HDR_LEN;
                            phase_next    = PH_BODY;
                        end
                    end else begin
                        // chunk start
                        if (phase_next == PH_BODY && pos_wide == boundary_next) begin
                            tally_next = tally_reg + 1'b1;
                            if (tally_next > icv_pkg::MAX_ENTRIES) begin
                                failed_next = 1'b1;
                            end
                            phase_next = PH_CHUNKHDR;
                        end
                        // last byte of the chunk length field
                        if (phase_next == PH_CHUNKHDR &&
                            pos_wide == boundary_next + 33'd7) begin
                            if (shift_icns < icv_pkg::ICNS_MIN_CHUNK) begin
                                failed_next = 1'b1;
                            end
                            boundary_next = boundary_next + {1'b0, shift_icns};
                            if (boundary_next > icv_pkg::MAX_FILE_BYTES) begin
                                failed_next = 1'b1;
                            end
                            phase_next = PH_BODY;
                        end
                    end
                end else begin
                    shift_next = shift_ico;
                    if (phase_reg == PH_HEADER) begin
                        if (pos_reg == 30'd1 && half != 16'd0) begin
                            failed_next = 1'b1;
                        end
                        if (pos_reg == 30'd3 && half != icv_pkg::ICO_TYPE_ICON) begin
                            failed_next = 1'b1;
                        end
                        if (pos_reg == 30'd5) begin
                            if (half == 16'd0 || half > {7'd0, icv_pkg::MAX_ENTRIES}) begin
                                failed_next = 1'b1;
                            end else begin
                                total_next  = half[8:0];
                                index_next  = 9'd0;
                                offset_next = icv_pkg::ICO_DIR_BASE +
                                              {20'd0, half[8:0], 4'd0};
                                phase_next  = PH_TABLE;
                            end
                        end
                    end else if (phase_reg == PH_TABLE) begin
                        if (rel == 4'd5 && half != icv_pkg::ICO_PLANES) begin
                            failed_next = 1'b1;
                        end
                        if (rel == 4'd7 && half != icv_pkg::ICO_BPP) begin
                            failed_next = 1'b1;
                        end
                        if (rel == 4'd11) begin
                            declared_next = shift_ico;
                            if (shift_ico == 32'd0) begin
                                failed_next = 1'b1;
                            end
                        end
                        if (rel == 4'd15) begin
                            if ({1'b0, shift_ico} != offset_reg) begin
                                failed_next = 1'b1;
                            end
                            offset_next = offset_reg + {1'b0, declared_reg};
                            if (offset_next > icv_pkg::MAX_FILE_BYTES) begin
                                failed_next = 1'b1;
                            end
                            index_next = index_reg + 1'b1;
                            if (index_next >= total_reg) begin
                                phase_next = PH_BODY;
                            end
                        end
                    end
                end
            end
        end
    end

    // Verdict at the final byte, from the updated state
    assign len_wide = {{(icv_pkg::OFS_W-icv_pkg::POS_W){1'b0}}, pos_next};

    always_comb begin
        verdict.ok    = 1'b0;
        verdict.count = 9'd0;
        if (format_sel == icv_pkg::FMT_ICNS) begin
            if (!failed_next && pos_next >= icv_pkg::ICNS_MIN_LEN &&
                phase_next == PH_BODY && {1'b0, declared_next} == len_wide &&
                boundary_next == len_wide && tally_next != 9'd0) begin
                verdict.ok    = 1'b1;
                verdict.count = tally_next;
            end
        end else begin
            if (!failed_next && phase_next == PH_BODY && offset_next == len_wide) begin
                verdict.ok    = 1'b1;
                verdict.count = total_next;
            end
        end
    end

    // Stream state; cleared on reset, format write and after each file
    always_ff @(posedge aclk) begin
        if (!aresetn || clear || (step && last_byte)) begin
            phase_reg    <= PH_HEADER;
            pos_reg      <= '0;
            shift_reg    <= '0;
            total_reg    <= '0;
            index_reg    <= '0;
            offset_reg   <= '0;
            declared_reg <= '0;
            boundary_reg <= '0;
            tally_reg    <= '0;
            failed_reg   <= 1'b0;
        end else if (step) begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            shift_reg    <= shift_next;
            total_reg    <= total_next;
            index_reg    <= index_next;
            offset_reg   <= offset_next;
            declared_reg <= declared_next;
            boundary_reg <= boundary_next;
            tally_reg    <= tally_next;
            failed_reg   <= failed_next;
        end
    end

endmodule

// ===== rtl/core/icon_container_validator_top.sv =====
// The verdict is registered at the transfer of the final byte and appears on m_ in the cycle after it.
// Throughput: one byte per cycle when not stalled; the whole parse step sits between the stream
// state registers and the output register.
// Input is stalled while a verdict waits in the output register and m_tready is low,
// and in a cycle with a format write.
// Reset (aresetn, synchronous, active low) clears the stream state, the output
// register valid flag and sets the format to ICO.
module icon_container_validator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,     // format_select
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] data_byte
    input  logic        s_tlast,      // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata       // [0] container_valid, [9:1] representation_count
);

    logic              format_reg;
    logic              out_valid_reg;
    icv_pkg::verdict_t out_reg;
    icv_pkg::verdict_t verdict;
    logic              cfg_write;
    logic              in_xfer;

    // a format write takes the cycle; no byte transfer alongside it
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid;
    assign s_tready  = (!out_valid_reg || m_tready) && !cfg_valid;
    assign in_xfer   = s_tvalid && s_tready;

    icv_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (cfg_write),
        .step       (in_xfer),
        .data_byte  (s_tdata),
        .last_byte  (s_tlast),
        .format_sel (format_reg),
        .verdict    (verdict)
    );

    // Format register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg <= icv_pkg::FMT_ICO;
        end else if (cfg_write) begin
            format_reg <= cfg_data;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_xfer && s_tlast) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && s_tlast) begin
            out_reg <= verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.count, out_reg.ok};

endmodule

// ===== rtl/core/icv_checker.sv =====
module icv_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // Output register empties on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("verdict pending after reset");

    // A held verdict does not change
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("verdict changed while stalled");

    // Invalid file reports no representations
    a_zero_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[9:1] == 9'd0)
        else $error("count non-zero on invalid file");

    // Valid file has between one and the maximum number of representations
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[9:1] != 9'd0 && m_tdata[9:1] <= 9'd256)
        else $error("count out of range on valid file");

    // A new verdict follows a final-byte transfer
    a_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("verdict without final byte");

endmodule

bind icon_container_validator_top icv_port_checker u_icv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/icv_checker.sv =====
`timescale 1ns / 100ps

// Watches the config, byte and verdict channels, predicts every verdict from
// the accepted bytes and compares it with what leaves on m_.
module icv_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,       // format_select
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,        // [7:0] data_byte
    input  logic        s_tlast,        // last_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,        // [0] container_valid, [9:1] representation_count
    output int          pending_verdicts,
    output int          mismatch_count
);

    localparam logic [32:0] FILE_BYTE_CAP  = 33'd536870912;
    localparam logic [15:0] ENTRY_CAP      = 16'd256;
    localparam logic [31:0] ICNS_TAG       = 32'h69636e73;
    localparam logic [29:0] ICNS_SHORTEST  = 30'd17;
    localparam logic [31:0] CHUNK_SHORTEST = 32'd9;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TABLE,
        PH_BODY,
        PH_CHUNKHDR
    } phase_t;

    typedef struct packed {
        logic       ok;
        logic [8:0] count;
    } verdict_t;

    verdict_t    verdict_q[$];

    // predictor state
    logic        fmt_sel;
    phase_t      phase;
    logic [29:0] byte_pos;
    logic [31:0] shift_word;
    logic [8:0]  entry_total;
    logic [8:0]  entry_index;
    logic [32:0] run_ofs;
    logic [31:0] declared_len;
    logic [32:0] chunk_end;
    logic [9:0]  chunk_tally;
    logic        failed;

    initial begin
        pending_verdicts = 0;
        mismatch_count   = 0;
    end

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic restart_parse();
        phase        = PH_HEADER;
        byte_pos     = '0;
        shift_word   = '0;
        entry_total  = '0;
        entry_index  = '0;
        run_ofs      = '0;
        declared_len = '0;
        chunk_end    = '0;
        chunk_tally  = '0;
        failed       = 1'b0;
    endtask

    // ICO: little-endian fields, the newest 16 bits sit at the top of the shifter
    task automatic ico_byte(input logic [29:0] pos, input logic [7:0] b);
        logic [15:0] half;
        logic [3:0]  rel;
        shift_word = {b, shift_word[31:8]};
        half       = shift_word[31:16];
        rel        = pos[3:0] - 4'd6;
        case (phase)
            PH_HEADER: begin
                if (pos == 30'd1 && half != 16'd0) failed = 1'b1;
                if (pos == 30'd3 && half != 16'd1) failed = 1'b1;
                if (pos == 30'd5) begin
                    if (half == 16'd0 || half > ENTRY_CAP) begin
                        failed = 1'b1;
                    end else begin
                        entry_total = half[8:0];
                        entry_index = '0;
                        run_ofs     = 33'd6 + {half, 4'b0000};
                        phase       = PH_TABLE;
                    end
                end
            end
            PH_TABLE: begin
                if (rel == 4'd5 && half != 16'd1) failed = 1'b1;
                if (rel == 4'd7 && half != 16'd32) failed = 1'b1;
                if (rel == 4'd11) begin
                    declared_len = shift_word;
                    if (shift_word == 32'd0) failed = 1'b1;
                end
                if (rel == 4'd15) begin
                    if ({1'b0, shift_word} != run_ofs) failed = 1'b1;
                    run_ofs = run_ofs + {1'b0, declared_len};
                    if (run_ofs > FILE_BYTE_CAP) failed = 1'b1;
                    entry_index++;
                    if (entry_index >= entry_total) phase = PH_BODY;
                end
            end
            default: ;
        endcase
    endtask

    // ICNS: big-endian fields, chunks walked by their length word
    task automatic icns_byte(input logic [29:0] pos, input logic [7:0] b);
        logic [7:0] tag_byte;
        shift_word = {shift_word[23:0], b};
        tag_byte   = 8'(ICNS_TAG >> (24 - 8 * int'(pos[1:0])));
        if (phase == PH_HEADER) begin
            if (pos < 30'd4 && b != tag_byte) failed = 1'b1;
            if (pos == 30'd7) begin
                declared_len = shift_word;
                chunk_end    = 33'd8;
                phase        = PH_BODY;
            end
        end else begin
            if (phase == PH_BODY && {3'b000, pos} == chunk_end) begin
                chunk_tally++;
                if (chunk_tally > 10'(ENTRY_CAP)) failed = 1'b1;
                phase = PH_CHUNKHDR;
            end
            if (phase == PH_CHUNKHDR && {4'b0000, pos} == {1'b0, chunk_end} + 34'd7) begin
                if (shift_word < CHUNK_SHORTEST) failed = 1'b1;
                chunk_end = chunk_end + {1'b0, shift_word};
                if (chunk_end > FILE_BYTE_CAP) failed = 1'b1;
                phase = PH_BODY;
            end
        end
    endtask

    // one accepted byte; on the last byte the verdict is queued
    task automatic take_byte(input logic [7:0] b, input logic last);
        logic [29:0] pos;
        verdict_t    v;
        pos = byte_pos;
        if ({3'b000, pos} >= FILE_BYTE_CAP) begin
            failed = 1'b1;
        end else begin
            byte_pos = pos + 30'd1;
            if (!failed) begin
                if (fmt_sel == icv_pkg::FMT_ICNS) icns_byte(pos, b);
                else ico_byte(pos, b);
            end
        end
        if (last) begin
            if (fmt_sel == icv_pkg::FMT_ICO) begin
                v.ok    = !failed && phase == PH_BODY && run_ofs == {3'b000, byte_pos};
                v.count = entry_total;
            end else begin
                v.ok    = !failed && byte_pos >= ICNS_SHORTEST && phase == PH_BODY &&
                          declared_len == {2'b00, byte_pos} &&
                          chunk_end == {3'b000, byte_pos} && chunk_tally != 10'd0;
                v.count = chunk_tally[8:0];
            end
            if (!v.ok) v.count = '0;
            verdict_q.push_back(v);
            restart_parse();
        end
    endtask

    // verdict compare first: it always belongs to an older file than a byte in the same cycle
    always @(posedge aclk) begin
        verdict_t got_exp;
        if (!aresetn) begin
            fmt_sel = icv_pkg::FMT_ICO;
            restart_parse();
            verdict_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    flag_mismatch($sformatf("verdict 0x%04h with none expected", m_tdata));
                end else begin
                    got_exp = verdict_q.pop_front();
                    if (m_tdata[0] !== got_exp.ok)
                        flag_mismatch($sformatf("container_valid %b, expected %b",
                                                m_tdata[0], got_exp.ok));
                    if (m_tdata[9:1] !== got_exp.count)
                        flag_mismatch($sformatf("representation_count %0d, expected %0d",
                                                m_tdata[9:1], got_exp.count));
                end
            end
            if (cfg_valid && cfg_ready) begin
                fmt_sel = cfg_data;
                restart_parse();
            end
            if (s_tvalid && s_tready) take_byte(s_tdata, s_tlast);
        end
        pending_verdicts = verdict_q.size();
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int VERDICT_LAT  = 1;
    localparam int STALL_LIMIT  = 2000;
    localparam int RAND_FILES   = 2;
    localparam int RAND_BYTES   = 500;
    localparam int ICO_MAX_DIR  = 256;
    localparam logic [31:0] ICNS_TAG = 32'h69636e73;

    // kinds of damage applied to a generated file
    typedef enum int {
        FLAW_NONE,
        FLAW_HEADER,
        FLAW_TYPE,
        FLAW_COUNT,
        FLAW_FIELD,
        FLAW_ZERO_LEN,
        FLAW_HUGE_LEN,
        FLAW_OFFSET,
        FLAW_SHORT,
        FLAW_LONG,
        FLAW_NOISE
    } flaw_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    int          pending_verdicts;
    int          mismatch_count;
    int          stall_cycles = 0;
    int          tx_gap_pct = 6;
    int          rx_gap_pct = 62;
    int          bytes_sent = 0;
    logic        cur_fmt = icv_pkg::FMT_ICO;
    logic [7:0]  file_bytes[$];

    always #5 aclk = ~aclk;

    icon_container_validator_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    icv_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .pending_verdicts (pending_verdicts),
        .mismatch_count   (mismatch_count)
    );

    // receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_gap_pct);
    end

    // watchdog: cycles with no transfer on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("[%0t] no transfer for %0d cycles", $realtime, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    task automatic put_le(input logic [31:0] v, input int nbytes);
        for (int i = 0; i < nbytes; i++) file_bytes.push_back(v[8*i +: 8]);
    endtask

    task automatic put_be32(input logic [31:0] v);
        for (int i = 0; i < 4; i++) file_bytes.push_back(v[31-8*i -: 8]);
    endtask

    // Build one container file into file_bytes. tight gives the shortest legal
    // representations (one byte ICO images, nine byte ICNS chunks).
    task automatic build_file(input logic fmt, input int n, input flaw_t flaw, input bit tight);
        logic [31:0] len;
        logic [31:0] word;
        int          spoil;
        int          body;
        int          which;
        file_bytes.delete();
        if (flaw == FLAW_COUNT)
            n = (fmt == icv_pkg::FMT_ICNS || $urandom_range(1)) ? 0 : $urandom_range(65535, 257);
        spoil = (n > 0) ? $urandom_range(n - 1) : 0;
        which = $urandom_range(1);
        body  = 0;
        if (flaw == FLAW_NOISE) begin
            repeat ($urandom_range(24, 1)) file_bytes.push_back(8'($urandom));
        end else if (fmt == icv_pkg::FMT_ICO) begin
            // header: reserved, type, count
            put_le((flaw == FLAW_HEADER) ? $urandom_range(16'hffff, 1) : 32'd0, 2);
            put_le((flaw == FLAW_TYPE) ? 32'd1 ^ (32'd1 << $urandom_range(15)) : 32'd1, 2);
            put_le(n, 2);
            word = 6 + 16 * n;
            if (n >= 1 && n <= ICO_MAX_DIR) begin
                for (int i = 0; i < n; i++) begin
                    len = tight ? 32'd1 : $urandom_range(8, 1);
                    if (i == spoil && flaw == FLAW_ZERO_LEN) len = 0;
                    if (i == spoil && flaw == FLAW_HUGE_LEN)
                        len = $urandom_range(1) ? 32'hffff_ffff :
                              $urandom_range(32'hffff_fffe, 32'h1fff_f000);
                    repeat (4) file_bytes.push_back(8'($urandom));
                    put_le((i == spoil && flaw == FLAW_FIELD && which == 0) ?
                           32'd1 ^ (32'd1 << $urandom_range(15)) : 32'd1, 2);
                    put_le((i == spoil && flaw == FLAW_FIELD && which == 1) ?
                           32'd32 ^ (32'd1 << $urandom_range(15)) : 32'd32, 2);
                    put_le(len, 4);
                    put_le((i == spoil && flaw == FLAW_OFFSET) ?
                           word ^ (32'd1 << $urandom_range(31)) : word, 4);
                    word = word + len;
                    if (len <= 8) body += len;
                end
            end else begin
                body = $urandom_range(20);
            end
            repeat (body) file_bytes.push_back(8'($urandom));
        end else begin
            // magic, then room for the big-endian total
            for (int i = 0; i < 4; i++)
                file_bytes.push_back(ICNS_TAG[31-8*i -: 8] ^
                    ((flaw == FLAW_HEADER && i == which + 2 * (spoil & 1)) ?
                     8'(1 << $urandom_range(7)) : 8'h00));
            repeat (4) file_bytes.push_back(8'h00);
            for (int i = 0; i < n; i++) begin
                len  = (tight || $urandom_range(1)) ? 32'd9 : $urandom_range(24, 9);
                body = len - 8;
                if (i == spoil && flaw == FLAW_FIELD) begin
                    len  = $urandom_range(8);
                    body = $urandom_range(3);
                end
                if (i == spoil && flaw == FLAW_ZERO_LEN) begin
                    len  = 0;
                    body = $urandom_range(3);
                end
                if (i == spoil && flaw == FLAW_HUGE_LEN) begin
                    len  = $urandom_range(1) ? 32'hffff_ffff :
                           $urandom_range(32'hffff_fffe, 32'h1fff_fff0);
                    body = 2;
                end
                word = (i == spoil && flaw == FLAW_OFFSET) ? len + $urandom_range(3, 1) : len;
                repeat (4) file_bytes.push_back(8'($urandom));
                put_be32(word);
                repeat (body) file_bytes.push_back(8'($urandom));
            end
            word = file_bytes.size();
            if (flaw == FLAW_TYPE) word = word ^ (32'd1 << $urandom_range(31));
            for (int i = 0; i < 4; i++) file_bytes[4+i] = word[31-8*i -: 8];
        end
        if (flaw == FLAW_SHORT && file_bytes.size() > 1)
            repeat ($urandom_range(file_bytes.size() - 1, 1)) void'(file_bytes.pop_back());
        if (flaw == FLAW_LONG)
            repeat ($urandom_range(4, 1)) file_bytes.push_back(8'($urandom));
    endtask

    // one byte transfer; returns at the falling edge after acceptance
    task automatic offer_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // sender and receiver idling by how far through the byte budget the run is
    task automatic set_pace();
        if (bytes_sent < RAND_BYTES / 3) begin
            tx_gap_pct = 6;
            rx_gap_pct = 62;
        end else if (bytes_sent < 2 * RAND_BYTES / 3) begin
            tx_gap_pct = 62;
            rx_gap_pct = 6;
        end else begin
            tx_gap_pct = 0;
            rx_gap_pct = 0;
        end
    endtask

    task automatic stream_file(input bit with_last);
        set_pace();
        foreach (file_bytes[i])
            offer_byte(file_bytes[i], with_last && i == file_bytes.size() - 1);
        bytes_sent += file_bytes.size();
    endtask

    // hold the sender until every verdict is out and the block has gone quiet
    task automatic drain_verdicts();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_verdicts != 0) @(negedge aclk);
        repeat (VERDICT_LAT + 1) @(negedge aclk);
    endtask

    task automatic select_format(input logic fmt);
        cfg_valid <= 1'b1;
        cfg_data  <= fmt;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
        cur_fmt = fmt;
    endtask

    initial begin
        logic  fmt;
        int    n;
        int    roll;
        flaw_t flaw;

        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed ICO: shortest directory, counts above the bound, each kind of damage
        select_format(icv_pkg::FMT_ICO);
        build_file(icv_pkg::FMT_ICO, 1, FLAW_NONE, 1'b1);
        stream_file(1'b1);
        build_file(icv_pkg::FMT_ICO, ICO_MAX_DIR + 1, FLAW_NONE, 1'b0);
        stream_file(1'b1);
        build_file(icv_pkg::FMT_ICO, 65535, FLAW_NONE, 1'b0);
        stream_file(1'b1);
        for (int f = FLAW_HEADER; f <= FLAW_NOISE; f++) begin
            build_file(icv_pkg::FMT_ICO, 1, flaw_t'(f), 1'b1);
            stream_file(1'b1);
        end
        // file ending inside the header, and a one byte file
        build_file(icv_pkg::FMT_ICO, 1, FLAW_NONE, 1'b0);
        file_bytes = file_bytes[0:2];
        stream_file(1'b1);
        file_bytes = '{8'hff};
        stream_file(1'b1);

        // format change part way through a file
        build_file(icv_pkg::FMT_ICO, 2, FLAW_NONE, 1'b0);
        file_bytes = file_bytes[0:9];
        stream_file(1'b0);
        drain_verdicts();
        select_format(icv_pkg::FMT_ICNS);

        // directed ICNS: shortest legal file, then each kind of damage
        build_file(icv_pkg::FMT_ICNS, 1, FLAW_NONE, 1'b1);
        stream_file(1'b1);
        for (int f = FLAW_HEADER; f <= FLAW_NOISE; f++) begin
            build_file(icv_pkg::FMT_ICNS, 1, flaw_t'(f), 1'b1);
            stream_file(1'b1);
        end
        drain_verdicts();
        select_format(icv_pkg::FMT_ICNS);

        // random files: mostly well formed, some damaged, some noise
        for (int i = 0; i < RAND_FILES || bytes_sent < RAND_BYTES; i++) begin
            fmt = logic'($urandom_range(1));
            if (fmt != cur_fmt || $urandom_range(9) == 0) begin
                drain_verdicts();
                select_format(fmt);
            end else if ($urandom_range(7) == 0) begin
                drain_verdicts();
            end
            roll = $urandom_range(99);
            if (roll < 65)
                flaw = FLAW_NONE;
            else if (roll < 90)
                flaw = flaw_t'($urandom_range(FLAW_LONG, FLAW_HEADER));
            else
                flaw = FLAW_NOISE;
            n = ($urandom_range(19) == 0) ? $urandom_range(40, 5) : $urandom_range(4, 1);
            build_file(cur_fmt, n, flaw, $urandom_range(3) == 0);
            stream_file(1'b1);
        end

        // wait for the last verdicts, then stay quiet to catch strays
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_verdicts != 0) @(negedge aclk);
        repeat (VERDICT_LAT + 8) @(negedge aclk);
        if (mismatch_count == 0 && pending_verdicts == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/icv_pkg.sv
rtl/core/icv_parser.sv
rtl/core/icon_container_validator_top.sv
rtl/core/icv_checker.sv
bench/icv_checker.sv
bench/tb_top.sv
